@@ sv/ftda_pkg.sv @@
// shared constants, types and state codes of the float to decimal text formatter
package ftda_pkg;

  localparam int unsigned MAX_PRECISION = 6;
  localparam int unsigned PREC_W        = 3;
  localparam int unsigned INT_BITS      = 31;
  localparam int unsigned INT_DIGITS    = 10;
  localparam int unsigned BCD_W         = 4 * INT_DIGITS;
  localparam int unsigned FRAC_W        = 48;
  localparam int unsigned MANT_W        = 24;
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned IDX_W         = 4;

  localparam logic [ADDR_W-1:0] ADDR_PRECISION = 3'd0;
  localparam logic [PREC_W-1:0] PREC_RESET     = 3'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_DOT   = 8'd46;

  localparam logic [7:0] EXP_SAT  = 8'd158;
  localparam logic [7:0] EXP_INT  = 8'd150;
  localparam logic [7:0] EXP_SUB  = 8'd149;
  localparam logic [7:0] EXP_NAN  = 8'hFF;
  localparam logic [7:0] SHIFT_LIM = 8'd72;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_INT,
    S_DOT,
    S_FRAC
  } state_t;

  typedef struct packed {
    logic                neg;
    logic [INT_BITS-1:0] ipart;
    logic [FRAC_W-1:0]   frac;
  } unpack_t;

endpackage

@@ sv/ftda_unpack.sv @@
// splits a single-precision pattern into sign, integer part and binary fraction
module ftda_unpack (
  input  logic [31:0]      value_bits,
  output ftda_pkg::unpack_t res
);

  logic [7:0]  expo;
  logic [22:0] mfrac;
  logic [23:0] mant;
  logic [7:0]  shr;
  logic [2:0]  shl;
  logic [71:0] aligned;
  logic [30:0] widened;
  logic        is_nan;

  always_comb begin
    expo    = value_bits[30:23];
    mfrac   = value_bits[22:0];
    is_nan  = (expo == ftda_pkg::EXP_NAN) && (mfrac != 23'd0);
    mant    = (expo == 8'd0) ? {1'b0, mfrac} : {1'b1, mfrac};
    shr     = (expo == 8'd0) ? ftda_pkg::EXP_SUB : (ftda_pkg::EXP_INT - expo);
    shl     = 3'(expo - ftda_pkg::EXP_INT);
    aligned = {mant, 48'd0} >> shr[6:0];
    widened = {7'd0, mant} << shl;

    res.neg = value_bits[31] && !is_nan && (value_bits[30:0] != 31'd0);
    if (expo >= ftda_pkg::EXP_SAT) begin
      // saturate, also infinities and nan
      res.ipart = 31'h7FFF_FFFF;
      res.frac  = '0;
    end else if (expo >= ftda_pkg::EXP_INT) begin
      res.ipart = widened;
      res.frac  = '0;
    end else if (shr >= ftda_pkg::SHIFT_LIM) begin
      res.ipart = '0;
      res.frac  = '0;
    end else begin
      res.ipart = {7'd0, aligned[71:48]};
      res.frac  = aligned[47:0];
    end
  end

endmodule

@@ sv/ftda_dabble.sv @@
// bit-serial binary to bcd converter for the integer part (shift and add 3)
module ftda_dabble (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ftda_pkg::INT_BITS-1:0]    bin,
  output logic                             done,
  output logic [ftda_pkg::BCD_W-1:0]       bcd,
  output logic [ftda_pkg::IDX_W-1:0]       ndig
);

  logic [ftda_pkg::INT_BITS-1:0] bin_r, bin_nxt;
  logic [ftda_pkg::BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [ftda_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ftda_pkg::BCD_W-1:0]    adj;

  always_comb begin
    for (int i = 0; i < ftda_pkg::INT_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (start) begin
      bin_nxt = bin;
      bcd_nxt = '0;
      cnt_nxt = ftda_pkg::CNT_W'(ftda_pkg::INT_BITS);
    end else if (cnt_r != '0) begin
      bcd_nxt = {adj[ftda_pkg::BCD_W-2:0], bin_r[ftda_pkg::INT_BITS-1]};
      bin_nxt = {bin_r[ftda_pkg::INT_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  // count of significant digits, at least one
  always_comb begin
    ndig = 4'd1;
    for (int i = 0; i < ftda_pkg::INT_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        ndig = ftda_pkg::IDX_W'(i + 1);
      end
    end
  end

  assign done = (cnt_r == '0);
  assign bcd  = bcd_r;

endmodule

@@ sv/ftda_fracgen.sv @@
// fraction digit generator: one times-ten step per decimal digit
module ftda_fracgen (
  input  logic                         clk,
  input  logic                         load,
  input  logic [ftda_pkg::FRAC_W-1:0]  frac,
  input  logic                         step,
  output logic [3:0]                   digit
);

  logic [ftda_pkg::FRAC_W-1:0] frac_r, frac_nxt;
  logic [ftda_pkg::FRAC_W+3:0] prod;

  always_comb begin
    prod  = ({4'd0, frac_r} << 3) + ({4'd0, frac_r} << 1);
    digit = prod[ftda_pkg::FRAC_W+3:ftda_pkg::FRAC_W];
    frac_nxt = frac_r;
    if (load) begin
      frac_nxt = frac;
    end else if (step) begin
      frac_nxt = prod[ftda_pkg::FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_nxt;
  end

endmodule

@@ sv/float_to_decimal_ascii.sv @@
// top level: float to decimal ascii text formatter with apb precision register
//
// input channel: in_valid/in_ready carry one single-precision bit pattern per item.
// output channel: out_valid/out_ready carry one ascii character per item, out_last
// marks the final character of a value's text: optional '-', integer digits without
// leading zeros, then '.' and precision_digits truncated fraction digits if nonzero.
// an accepted value first passes the serial binary to bcd converter (31 shift
// steps, one bit of the 31-bit integer part each, then the converter reports done),
// then one character leaves per cycle while out_ready allows, at most 18 characters.
// a new value is accepted once the previous text has been handed to the output
// register, so it may enter while the last character still waits there.
// when out_ready is low the output register holds and the formatter waits.
// register 0 at byte address 0: precision_digits, reset 3, values above 6 act as 6;
// write it only while idle. reset (rst_n low, synchronous) empties the output and
// returns to idle.
module float_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   in_value_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_character,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftda_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  ftda_pkg::state_t state_r, state_nxt;
  ftda_pkg::unpack_t unp;

  logic [ftda_pkg::PREC_W-1:0] cfg_prec_r;
  logic [ftda_pkg::PREC_W-1:0] prec_r, prec_nxt;
  logic [ftda_pkg::PREC_W-1:0] fcnt_r, fcnt_nxt;
  logic [ftda_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                        neg_r, neg_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        accept;
  logic                        slot_free;
  logic                        emit;
  logic                        conv_done;
  logic [ftda_pkg::BCD_W-1:0]  bcd;
  logic [ftda_pkg::IDX_W-1:0]  ndig;
  logic [3:0]                  int_digit;
  logic [3:0]                  frac_digit;
  logic                        frac_step;
  logic [ftda_pkg::PREC_W-1:0] prec_sat;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_prec_r <= ftda_pkg::PREC_RESET;
    end else if (psel && penable && pwrite && (paddr == ftda_pkg::ADDR_PRECISION)) begin
      cfg_prec_r <= pwdata[ftda_pkg::PREC_W-1:0];
    end
  end

  assign prdata = (paddr == ftda_pkg::ADDR_PRECISION) ?
                  {{(32-ftda_pkg::PREC_W){1'b0}}, cfg_prec_r} : 32'd0;

  assign prec_sat = (cfg_prec_r > ftda_pkg::PREC_W'(ftda_pkg::MAX_PRECISION)) ?
                    ftda_pkg::PREC_W'(ftda_pkg::MAX_PRECISION) : cfg_prec_r;

  ftda_unpack u_unpack (
    .value_bits (in_value_bits),
    .res        (unp)
  );

  ftda_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .bin   (unp.ipart),
    .done  (conv_done),
    .bcd   (bcd),
    .ndig  (ndig)
  );

  ftda_fracgen u_fracgen (
    .clk   (clk),
    .load  (accept),
    .frac  (unp.frac),
    .step  (frac_step),
    .digit (frac_digit)
  );

  assign in_ready  = (state_r == ftda_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign int_digit = bcd[4*idx_r +: 4];

  always_comb begin
    state_nxt     = state_r;
    prec_nxt      = prec_r;
    fcnt_nxt      = fcnt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    emit          = 1'b0;
    frac_step     = 1'b0;
    unique case (state_r)
      ftda_pkg::S_IDLE: begin
        if (accept) begin
          neg_nxt   = unp.neg;
          prec_nxt  = prec_sat;
          state_nxt = ftda_pkg::S_CONV;
        end
      end
      ftda_pkg::S_CONV: begin
        if (conv_done) begin
          idx_nxt   = ndig - 1'b1;
          state_nxt = neg_r ? ftda_pkg::S_SIGN : ftda_pkg::S_INT;
        end
      end
      ftda_pkg::S_SIGN: begin
        if (slot_free) begin
          emit         = 1'b1;
          out_char_nxt = ftda_pkg::CHAR_MINUS;
          out_last_nxt = 1'b0;
          state_nxt    = ftda_pkg::S_INT;
        end
      end
      ftda_pkg::S_INT: begin
        if (slot_free) begin
          emit         = 1'b1;
          out_char_nxt = ftda_pkg::CHAR_ZERO + {4'd0, int_digit};
          out_last_nxt = (idx_r == '0) && (prec_r == '0);
          if (idx_r == '0) begin
            state_nxt = (prec_r == '0) ? ftda_pkg::S_IDLE : ftda_pkg::S_DOT;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      ftda_pkg::S_DOT: begin
        if (slot_free) begin
          emit         = 1'b1;
          out_char_nxt = ftda_pkg::CHAR_DOT;
          out_last_nxt = 1'b0;
          fcnt_nxt     = prec_r;
          state_nxt    = ftda_pkg::S_FRAC;
        end
      end
      ftda_pkg::S_FRAC: begin
        if (slot_free) begin
          emit         = 1'b1;
          frac_step    = 1'b1;
          out_char_nxt = ftda_pkg::CHAR_ZERO + {4'd0, frac_digit};
          out_last_nxt = (fcnt_r == ftda_pkg::PREC_W'(1));
          fcnt_nxt     = fcnt_r - 1'b1;
          if (fcnt_r == ftda_pkg::PREC_W'(1)) begin
            state_nxt = ftda_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ftda_pkg::S_IDLE;
      end
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ftda_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prec_r     <= prec_nxt;
    fcnt_r     <= fcnt_nxt;
    idx_r      <= idx_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

`ifndef ASSERT_OFF
  a_accept_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ftda_pkg::S_CONV))
    else $error("accepted item did not start conversion");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_last_nxt) |=> (state_r == ftda_pkg::S_IDLE))
    else $error("formatter not idle after final character");

  a_int_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ftda_pkg::S_INT) |-> (int_digit <= 4'd9) && (idx_r < ndig))
    else $error("bad integer digit or index");

  a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ftda_pkg::S_FRAC) |->
      (fcnt_r != '0) && (fcnt_r <= ftda_pkg::PREC_W'(ftda_pkg::MAX_PRECISION)))
    else $error("fraction digit count out of range");
`endif

endmodule
